// ----- rtl/keyed_table_unique_insert_defines.svh -----
// assertion macros for the keyed table block
`ifndef KEYED_TABLE_UNIQUE_INSERT_DEFINES_SVH
`define KEYED_TABLE_UNIQUE_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define KTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KTI_ASSERT_NOW(lbl, ante, cons, msg)
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/kti_pkg.sv -----
// shared types, codes and defaults for the keyed table block
package kti_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int KEY_BITS         = 32;
    localparam int COUNT_OUT_BITS   = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic start;
        logic scan;
        logic rd_last;
        logic move;
        logic respond;
    } kti_cmd_t;

    typedef struct packed {
        logic match;
        logic scan_end;
        logic is_remove;
        logic out_free;
    } kti_sts_t;

endpackage

// ----- rtl/keyed_table_unique_insert.sv -----
// keyed table top level: linear-search insert, lookup and remove
// a request scans the stored entries in slot order until its key matches or all are
// read, and a remove that hits then moves the last entry into the hole; no new request
// is accepted until the result is registered. the scan reads one entry per cycle
// from the single ram read port. the result register frees the input side while a word waits.
// reset clears the entry count and control; table contents are not cleared.
`include "keyed_table_unique_insert_defines.svh"
module keyed_table_unique_insert
    import kti_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], payload[63:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // found_payload[31:0], entry_count[38:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    kti_cmd_t                  cmd;
    kti_sts_t                  sts;
    logic [1:0]                out_status;
    logic [31:0]               out_found;
    logic [COUNT_OUT_BITS-1:0] out_count;

    kti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kti_dp #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_key     (s_tdata[31:0]),
        .in_payload (s_tdata[63:32]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_found  (out_found),
        .out_count  (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_found};
    assign m_tuser = out_status;

    `KTI_ASSERT_NEXT(a_busy_after_accept, cmd.start, !s_tready, "ready high right after accept")
    `KTI_ASSERT_NOW(a_count_bound, m_tvalid && (CAPACITY <= 127),
        out_count <= COUNT_OUT_BITS'(CAPACITY), "entry count above capacity")
    `KTI_ASSERT_NOW(a_full_count, m_tvalid && (out_status == ST_FULL),
        out_count == COUNT_OUT_BITS'(CAPACITY), "full status with table not full")
    `KTI_ASSERT_NOW(a_found_ok, m_tvalid && (out_found != 32'd0),
        out_status == ST_OK, "payload shown without ok status")

endmodule

// ----- rtl/kti_ram.sv -----
// generic single-write, single-read ram with registered read data
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/kti_ctrl.sv -----
// sequencing state machine for the keyed table
module kti_ctrl
    import kti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  kti_sts_t sts,
    output kti_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (sts.match)
                begin
                    state_next = sts.is_remove ? S_LAST : S_RESP;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_LAST:  state_next = S_MOVE;
            S_MOVE:  state_next = S_RESP;
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.start   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.rd_last = (state_reg == S_LAST);
    assign cmd.move    = (state_reg == S_MOVE);
    assign cmd.respond = (state_reg == S_RESP) && sts.out_free;

endmodule

// ----- rtl/kti_dp.sv -----
// table storage, scan compare, count and result register
module kti_dp
    import kti_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kti_cmd_t                  cmd,
    output kti_sts_t                  sts,
    input  logic [1:0]                in_op,
    input  logic [KEY_BITS-1:0]       in_key,
    input  logic [31:0]               in_payload,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [1:0]                out_status,
    output logic [31:0]               out_found,
    output logic [COUNT_OUT_BITS-1:0] out_count
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_BITS + PAYLOAD_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [1:0]              op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [CW-1:0]           idx_reg;
    logic                    pend_reg;
    logic                    hit_reg;
    logic [AW-1:0]           hit_idx_reg;
    logic [31:0]             found_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    logic                      out_valid_reg;
    logic [1:0]                out_status_reg;
    logic [31:0]               out_found_reg;
    logic [COUNT_OUT_BITS-1:0] out_count_reg;

    logic [DW-1:0]       rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic                match;
    logic                issue;
    logic [CW-1:0]       idx_prev;
    logic [CW-1:0]       count_dec;
    logic                full;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [1:0]          status;
    logic [31:0]         found;
    logic                ins_ok;

    assign rd_key    = rd_data[KEY_BITS-1:0];
    assign match     = cmd.scan && pend_reg && (rd_key == key_reg);
    assign issue     = cmd.scan && (idx_reg != count_reg) && !match;
    assign idx_prev  = idx_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign full      = (count_reg >= CAP_C);

    assign sts.match     = match;
    assign sts.scan_end  = (idx_reg == count_reg) && !pend_reg;
    assign sts.is_remove = (op_reg == OP_REMOVE);
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        status     = ST_MISSING;
        found      = '0;
        ins_ok     = 1'b0;
        count_next = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                priority if (hit_reg)
                begin
                    status = ST_DUP;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    ins_ok     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    status = ST_OK;
                    found  = found_reg;
                end
            end
            OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    status     = ST_OK;
                    count_next = count_dec;
                end
            end
            default: status = ST_MISSING;
        endcase
    end

    // the ram write port serves the remove move and the insert append
    assign ram_we    = cmd.move || (cmd.respond && ins_ok);
    assign ram_waddr = cmd.move ? hit_idx_reg : count_reg[AW-1:0];
    assign ram_wdata = cmd.move ? rd_data : {pay_reg, key_reg};
    assign ram_raddr = cmd.rd_last ? count_dec[AW-1:0] : idx_reg[AW-1:0];

    kti_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                pend_reg <= issue;
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.respond)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
            pay_reg <= PAYLOAD_BITS'(in_payload);
        end
        if (match)
        begin
            // read data belongs to the previously issued slot, since the ram read is registered
            hit_idx_reg <= idx_prev[AW-1:0];
            found_reg   <= 32'(rd_data[DW-1:KEY_BITS]);
        end
        if (cmd.respond)
        begin
            out_status_reg <= status;
            out_found_reg  <= found;
            out_count_reg  <= COUNT_OUT_BITS'(count_next);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_count  = out_count_reg;

endmodule

// ----- test/keyed_table_unique_insert_tb.sv -----
// self-checking testbench for the keyed table: directed, full-table, random and backpressure tests
module keyed_table_unique_insert_tb;
    import kti_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int POOL_SIZE    = 100;
    localparam int DRAIN_CYCLES = 2 * CAP + 20;

    // op code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found;
        logic [6:0]  count;
    } reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // key[31:0], payload[63:32]
    logic [1:0]  s_tuser  = '0;    // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // found_payload[31:0], entry_count[38:32], zero pad
    logic [1:0]  m_tuser;          // status[1:0]

    // table shadow and pending replies
    logic [31:0] tbl_key     [CAP];
    logic [31:0] tbl_payload [CAP];
    int          tbl_count = 0;
    reply_t      replies_due [$];
    int          errors = 0;

    logic [31:0] key_pool [POOL_SIZE];
    bit          gaps_on = 1'b1;
    int          burst_left = 0;

    // receiver controls
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    logic [2:0]  rx_phase = '0;

    keyed_table_unique_insert uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // applies one request to the shadow table and returns the reply it must give
    function automatic reply_t table_apply(logic [1:0] op, logic [31:0] key,
                                           logic [31:0] payload);
        reply_t r;
        int     slot;
        slot     = -1;
        r.status = ST_MISSING;
        r.found  = '0;
        for (int i = 0; i < tbl_count; i++)
            if (slot < 0 && tbl_key[i] == key)
                slot = i;
        case (op)
            OP_INSERT:
                if (slot >= 0)
                    r.status = ST_DUP;
                else if (tbl_count >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    tbl_key[tbl_count]     = key;
                    tbl_payload[tbl_count] = payload;
                    tbl_count++;
                    r.status = ST_OK;
                end
            OP_LOOKUP:
                if (slot >= 0)
                begin
                    r.status = ST_OK;
                    r.found  = tbl_payload[slot];
                end
            OP_REMOVE:
                if (slot >= 0)
                begin
                    // last entry fills the hole
                    tbl_key[slot]     = tbl_key[tbl_count - 1];
                    tbl_payload[slot] = tbl_payload[tbl_count - 1];
                    tbl_count--;
                    r.status = ST_OK;
                end
            default: ;
        endcase
        r.count = 7'(tbl_count);
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the word, or after its gap
    task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] payload);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, key};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        replies_due.push_back(table_apply(op, key, payload));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(15, 0);
            gap = gaps_on ? $urandom_range(12, 1) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic test_directed();
        send_request(OP_REMOVE, 32'h0000_0000, 32'h1111_1111);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 32'h0000_0000, 32'ha5a5_a5a5);
        send_request(OP_INSERT, 32'hffff_ffff, 32'h5a5a_5a5a);
        send_request(OP_INSERT, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(OP_LOOKUP, 32'h7fff_ffff, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_LOOKUP, 32'hffff_ffff, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_0001, 32'h0);
        send_request(OP_LOOKUP, 32'hffff_fffe, 32'h0);
        // hole at slot 0 gets the last entry
        send_request(OP_REMOVE, 32'h8000_0000, 32'h0);
        send_request(OP_LOOKUP, 32'hffff_ffff, 32'h0);
        send_request(OP_REMOVE, 32'hffff_ffff, 32'h0);
        send_request(OP_REMOVE, 32'h1234_5678, 32'h0);
        send_request(OP_UNUSED, 32'h0000_0000, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
        // removing the only entry
        send_request(OP_REMOVE, 32'h7fff_ffff, 32'h0);
        send_request(OP_INSERT, 32'h7fff_ffff, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        while (tbl_count < CAP)
            send_request(OP_INSERT, $urandom, $urandom);
        // duplicate check wins over the full check
        send_request(OP_INSERT, tbl_key[5], $urandom);
        send_request(OP_INSERT, $urandom, $urandom);
        send_request(OP_LOOKUP, tbl_key[CAP - 1], 32'h0);
        send_request(OP_LOOKUP, tbl_key[0], 32'h0);
        send_request(OP_REMOVE, tbl_key[0], 32'h0);
        send_request(OP_LOOKUP, tbl_key[0], 32'h0);
        send_request(OP_INSERT, $urandom, $urandom);
        while (tbl_count > 0)
            send_request(OP_REMOVE, tbl_key[$urandom_range(tbl_count - 1, 0)], $urandom);
        send_request(OP_REMOVE, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(int phases, int per_phase);
        int          ins_w;
        int          lk_bound;
        int          pick;
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] payload;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 3)
                0:       ins_w = 65;
                1:       ins_w = 40;
                default: ins_w = 20;
            endcase
            lk_bound = ins_w + (95 - ins_w) / 2;
            gaps_on  = (p % 4 != 3);
            for (int n = 0; n < per_phase; n++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < ins_w)
                    op = OP_INSERT;
                else if (pick < lk_bound)
                    op = OP_LOOKUP;
                else if (pick < 95)
                    op = OP_REMOVE;
                else
                    op = OP_UNUSED;
                if ($urandom_range(99, 0) < 85)
                    key = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
                else
                    key = $urandom;
                pick = $urandom_range(19, 0);
                if (pick == 0)
                    payload = 32'h0;
                else if (pick == 1)
                    payload = 32'hffff_ffff;
                else
                    payload = $urandom;
                send_request(op, key, payload);
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while words keep coming, so the input side must stall
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req <= ~hold_req;
        for (int n = 0; n < 40; n++)
            send_request(n[0] ? OP_LOOKUP : OP_INSERT,
                         key_pool[$urandom_range(POOL_SIZE - 1, 0)], $urandom);
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= rx_mode_t'($urandom_range(3, 0));
                rx_mode_left <= $urandom_range(200, 20);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(1, 0));
                RX_SPARSE: m_tready <= ($urandom_range(5, 0) == 0);
                default:   m_tready <= rx_phase[2];
            endcase
            rx_phase <= rx_phase + 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: reply with nothing pending: status %0d payload %h count %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[38:32]);
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_tuser !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata[31:0] !== want.found)
                begin
                    errors++;
                    $display("%0t: found_payload expected %h actual %h",
                             $time, want.found, m_tdata[31:0]);
                end
                if (m_tdata[38:32] !== want.count)
                begin
                    errors++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, m_tdata[38:32]);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("keyed_table_unique_insert_tb failed");
        $finish;
    end

    initial
    begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random_traffic(12, 146);
        test_backpressure();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && replies_due.size() == 0)
            $display("keyed_table_unique_insert_tb passed");
        else
            $display("keyed_table_unique_insert_tb failed");
        $finish;
    end

endmodule
